// ===== rtl/core/csvct_pkg.sv =====
`default_nettype none

package csvct_pkg;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_DELIMITER_CHAR = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LAST_COLUMN    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MASK_ENABLE    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMN_MASK    = 2'd3;

   localparam logic [7:0] DELIMITER_RESET   = 8'd44;
   localparam logic [5:0] LAST_COLUMN_RESET = 6'd63;

   localparam logic [7:0] QUOTE_CHAR = 8'h22;
   localparam logic [7:0] LF_CHAR    = 8'h0A;
   localparam logic [7:0] CR_CHAR    = 8'h0D;

   localparam int unsigned NUM_COLUMNS_DEFAULT = 64;
   localparam int unsigned COL_W = 16;
   localparam logic [COL_W-1:0] COUNT_MAX = 16'hFFFF;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      ACT_CHAR,
      ACT_CELL_END,
      ACT_ROW_END,
      ACT_FLUSH
   } action_type;

   typedef enum logic [1:0] {
      KIND_CHAR     = 2'd0,
      KIND_CELL_END = 2'd1,
      KIND_ROW_END  = 2'd2
   } kind_type;

   typedef struct packed {
      action_type action;
      logic [7:0] char_val;
   } queue_entry_type;

   typedef struct packed {
      logic                   we;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } csr_write_type;

   function automatic logic [COL_W-1:0] sat_inc(input logic [COL_W-1:0] v);
      sat_inc = (v == COUNT_MAX) ? v : v + 1'b1;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/csvct_front.sv =====
`default_nettype none

module csvct_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire csvct_pkg::csr_write_type  csr,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [7:0]                req_tdata,
   input  wire logic                      req_tlast,
   output logic                           push_valid,
   output csvct_pkg::queue_entry_type     push_entry,
   input  wire logic                      queue_full
);
   import csvct_pkg::*;

   logic       inside_quotes_ff, inside_quotes_in;
   logic       quote_pending_ff, quote_pending_in;
   logic       swallow_lf_ff, swallow_lf_in;
   logic [7:0] delimiter_ff;
   logic       accept;
   logic       quoted;
   logic [7:0] ch;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign ch         = req_tdata;

   always_comb begin
      inside_quotes_in    = inside_quotes_ff;
      quote_pending_in    = quote_pending_ff;
      swallow_lf_in       = swallow_lf_ff;
      push_valid          = 1'b0;
      push_entry.action   = ACT_CHAR;
      push_entry.char_val = ch;
      quoted              = inside_quotes_ff;
      if (accept) begin
         if (req_tlast) begin
            push_valid        = 1'b1;
            push_entry.action = ACT_FLUSH;
            inside_quotes_in  = 1'b0;
            quote_pending_in  = 1'b0;
            swallow_lf_in     = 1'b0;
         end else if (swallow_lf_ff && ch == LF_CHAR) begin
            swallow_lf_in = 1'b0;
         end else if (quote_pending_ff && ch == QUOTE_CHAR) begin
            // doubled quote inside quotes: literal quote
            swallow_lf_in    = 1'b0;
            quote_pending_in = 1'b0;
            push_valid       = 1'b1;
         end else begin
            swallow_lf_in    = 1'b0;
            quote_pending_in = 1'b0;
            // a pending quote followed by anything else closes quoting
            quoted           = quote_pending_ff ? 1'b0 : inside_quotes_ff;
            inside_quotes_in = quoted;
            if (ch == QUOTE_CHAR) begin
               if (quoted) begin
                  quote_pending_in = 1'b1;
               end else begin
                  inside_quotes_in = 1'b1;
               end
            end else if (!quoted && ch == delimiter_ff) begin
               push_valid        = 1'b1;
               push_entry.action = ACT_CELL_END;
            end else if (!quoted && (ch == LF_CHAR || ch == CR_CHAR)) begin
               push_valid        = 1'b1;
               push_entry.action = ACT_ROW_END;
               swallow_lf_in     = (ch == CR_CHAR);
            end else begin
               push_valid = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_quotes_ff <= 1'b0;
         quote_pending_ff <= 1'b0;
         swallow_lf_ff    <= 1'b0;
         delimiter_ff     <= DELIMITER_RESET;
      end else begin
         inside_quotes_ff <= inside_quotes_in;
         quote_pending_ff <= quote_pending_in;
         swallow_lf_ff    <= swallow_lf_in;
         if (csr.we && csr.index == CSR_DELIMITER_CHAR) begin
            delimiter_ff <= csr.data[7:0];
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/csvct_queue.sv =====
`default_nettype none

module csvct_queue (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push_valid,
   input  wire csvct_pkg::queue_entry_type  push_entry,
   output logic                             full,
   output logic                             head_valid,
   output csvct_pkg::queue_entry_type       head_entry,
   input  wire logic                        pop
);
   import csvct_pkg::*;

   queue_entry_type        entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full       = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   // depth is a power of two, pointers wrap on their own
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/csvct_back.sv =====
`default_nettype none

module csvct_back #(
   parameter int unsigned NUM_COLUMNS = csvct_pkg::NUM_COLUMNS_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire csvct_pkg::csr_write_type    csr,
   input  wire logic                        head_valid,
   input  wire csvct_pkg::queue_entry_type  head_entry,
   output logic                             pop,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output csvct_pkg::kind_type              rsp_kind,
   output logic [7:0]                       rsp_char,
   output logic [csvct_pkg::COL_W-1:0]      rsp_column,
   output logic                             rsp_cell_kept,
   output logic [csvct_pkg::COL_W-1:0]      rsp_row_columns
);
   import csvct_pkg::*;

   localparam int unsigned IDX_W = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;

   logic [COL_W-1:0]       column_count_ff, column_count_in;
   logic                   cell_has_chars_ff, cell_has_chars_in;
   logic [5:0]             last_column_ff;
   logic                   mask_enable_ff;
   logic [NUM_COLUMNS-1:0] column_mask_ff;

   logic                   out_valid_ff, out_valid_in;
   kind_type               out_kind_ff, out_kind_in;
   logic [7:0]             out_char_ff, out_char_in;
   logic [COL_W-1:0]       out_column_ff, out_column_in;
   logic                   out_kept_ff, out_kept_in;
   logic [COL_W-1:0]       out_rowcols_ff, out_rowcols_in;

   logic                   col_kept;
   logic                   mask_bit;

   assign mask_bit = (column_count_ff < COL_W'(NUM_COLUMNS))
                     && column_mask_ff[column_count_ff[IDX_W-1:0]];
   assign col_kept = (column_count_ff <= {{(COL_W-6){1'b0}}, last_column_ff})
                     && (!mask_enable_ff || mask_bit);

   // output register free or being drained this cycle
   assign pop = head_valid && (!out_valid_ff || rsp_tready);

   always_comb begin
      column_count_in   = column_count_ff;
      cell_has_chars_in = cell_has_chars_ff;
      out_valid_in      = out_valid_ff && !rsp_tready;
      out_kind_in       = out_kind_ff;
      out_char_in       = out_char_ff;
      out_column_in     = out_column_ff;
      out_kept_in       = out_kept_ff;
      out_rowcols_in    = out_rowcols_ff;
      if (pop) begin
         out_valid_in   = 1'b0;
         out_char_in    = '0;
         out_column_in  = column_count_ff;
         out_kept_in    = 1'b0;
         out_rowcols_in = '0;
         unique case (head_entry.action) inside
            ACT_CHAR: begin
               out_kind_in = KIND_CHAR;
               out_char_in = head_entry.char_val;
               if (col_kept) begin
                  out_valid_in      = 1'b1;
                  cell_has_chars_in = 1'b1;
               end
            end
            ACT_CELL_END: begin
               out_kind_in       = KIND_CELL_END;
               out_valid_in      = col_kept;
               cell_has_chars_in = 1'b0;
               column_count_in   = sat_inc(column_count_ff);
            end
            ACT_ROW_END, ACT_FLUSH: begin
               out_kind_in       = KIND_ROW_END;
               out_kept_in       = col_kept;
               out_rowcols_in    = sat_inc(column_count_ff);
               // flush with nothing pending gives no word
               out_valid_in      = (head_entry.action == ACT_ROW_END)
                                   || (column_count_ff != '0) || cell_has_chars_ff;
               column_count_in   = '0;
               cell_has_chars_in = 1'b0;
            end
            default: begin
               out_kind_in = KIND_CHAR;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff   <= '0;
         cell_has_chars_ff <= 1'b0;
         out_valid_ff      <= 1'b0;
         last_column_ff    <= LAST_COLUMN_RESET;
         mask_enable_ff    <= 1'b0;
         column_mask_ff    <= '1;
      end else begin
         column_count_ff   <= column_count_in;
         cell_has_chars_ff <= cell_has_chars_in;
         out_valid_ff      <= out_valid_in;
         if (csr.we) begin
            case (csr.index)
               CSR_LAST_COLUMN: last_column_ff <= csr.data[5:0];
               CSR_MASK_ENABLE: mask_enable_ff <= csr.data[0];
               CSR_COLUMN_MASK: column_mask_ff <= csr.data[NUM_COLUMNS-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      out_kind_ff    <= out_kind_in;
      out_char_ff    <= out_char_in;
      out_column_ff  <= out_column_in;
      out_kept_ff    <= out_kept_in;
      out_rowcols_ff <= out_rowcols_in;
   end

   assign rsp_tvalid      = out_valid_ff;
   assign rsp_kind        = out_kind_ff;
   assign rsp_char        = out_char_ff;
   assign rsp_column      = out_column_ff;
   assign rsp_cell_kept   = out_kept_ff;
   assign rsp_row_columns = out_rowcols_ff;

endmodule

`default_nettype wire

// ===== rtl/core/csv_cell_tokenizer_core.sv =====
`default_nettype none

// Channel   Dir  Word contents
// req_      in   tdata[7:0] data_byte; tlast end_of_input
// rsp_      out  tdata data fields; tuser[1:0] kind
// csr_      in   write enable, index 0..3, 64-bit write data
//
// One byte per cycle while the queue has room: the front decodes quotes combinationally and
// the back updates the column counter as it pops each entry.
// A byte reaches its result word through the queue and then the output register.
// A 4-word queue separates front and back; req_tready drops when it is full.
// Reset is synchronous and active high; control registers return to their defaults.
module csv_cell_tokenizer_core #(
   parameter int unsigned NUM_COLUMNS = csvct_pkg::NUM_COLUMNS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [7:0]                         req_tdata,  // data_byte
   input  wire logic                               req_tlast,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // char_out[7:0], column[23:8], cell_kept[24], row_columns[40:25], zero fill
   output logic [47:0]                             rsp_tdata,
   output logic [1:0]                              rsp_tuser,  // kind
   input  wire logic                               csr_we,
   input  wire logic [csvct_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [csvct_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import csvct_pkg::*;

   csr_write_type   csr;
   logic            push_valid;
   queue_entry_type push_entry;
   logic            queue_full;
   logic            head_valid;
   queue_entry_type head_entry;
   logic            pop;
   kind_type        kind;
   logic [7:0]      char_out;
   logic [COL_W-1:0] column;
   logic            cell_kept;
   logic [COL_W-1:0] row_columns;

   assign csr.we    = csr_we;
   assign csr.index = csr_index;
   assign csr.data  = csr_wdata;

   csvct_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .queue_full (queue_full)
   );

   csvct_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop)
   );

   csvct_back #(
      .NUM_COLUMNS (NUM_COLUMNS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .csr             (csr),
      .head_valid      (head_valid),
      .head_entry      (head_entry),
      .pop             (pop),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_kind        (kind),
      .rsp_char        (char_out),
      .rsp_column      (column),
      .rsp_cell_kept   (cell_kept),
      .rsp_row_columns (row_columns)
   );

   assign rsp_tdata = {7'd0, row_columns, cell_kept, column, char_out};
   assign rsp_tuser = kind;

   // row end reports one more column than its last index, saturated
   a_row_columns: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && kind == KIND_ROW_END |-> row_columns == sat_inc(column))
      else $error("row end column total mismatch");

   // only row ends carry kept flag and column total
   a_other_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && kind != KIND_ROW_END |-> !cell_kept && row_columns == '0)
      else $error("row end fields set on non row end word");

   // delivered cells lie in the configurable column window
   a_kept_column: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (kind == KIND_CHAR || kind == KIND_CELL_END)
      |-> column[COL_W-1:6] == '0)
      else $error("delivered column outside window");

   // queue is never pushed while full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !queue_full)
      else $error("queue overflow");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none

module tb;
   import csvct_pkg::*;

   localparam int N_ITEMS      = 1400;
   localparam int PHASE_ITEMS  = 110;
   localparam int QUIET_ITEMS  = 200;
   localparam int HOLD_CYCLES  = 200;
   localparam int DRAIN_CYCLES = 8;
   localparam int STALL_LIMIT  = 2000;
   localparam int MAX_COLS     = NUM_COLUMNS_DEFAULT;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  ch;
      logic [15:0] column;
      logic        cell_kept;
      logic [15:0] row_columns;
   } token_t;

   typedef struct packed {
      logic [7:0] data;
      logic       eoi;
      logic       typed;
      logic       has_token;
      token_t     token;
   } dir_row_t;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata  = 8'd0;
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [47:0]            rsp_tdata;
   logic [1:0]             rsp_tuser;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = CSR_DELIMITER_CHAR;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   csv_cell_tokenizer_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // predictor copy of registers and tokenizer state
   logic [7:0]  cfg_delim    = DELIMITER_RESET;
   logic [5:0]  cfg_last_col = LAST_COLUMN_RESET;
   logic        cfg_mask_en  = 1'b0;
   logic [63:0] cfg_col_mask = '1;
   logic        pred_quoted  = 1'b0;
   logic        quote_pend   = 1'b0;
   logic        swallow_lf   = 1'b0;
   logic [15:0] col_count    = 16'd0;
   logic        cell_has     = 1'b0;

   token_t   expected_tokens[$];
   dir_row_t dir_tab[$];
   int       items_sent     = 0;
   int       mismatch_count = 0;
   int       stall_cycles   = 0;
   bit       quiet          = 1'b0;
   int       hold_reqs      = 0;
   int       hold_done      = 0;
   bit       typed_row      = 1'b0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic bit column_kept(input logic [15:0] c);
      if (c > cfg_last_col) return 1'b0;
      if (!cfg_mask_en) return 1'b1;
      return (c < MAX_COLS) && cfg_col_mask[c[5:0]];
   endfunction

   // advances the predicted tokenizer by one word; returns 1 when a token results
   function automatic bit tokenize_byte(input logic [7:0] b, input logic eoi,
                                        output token_t tok);
      bit emit;
      bit do_char;
      bit do_cell;
      bit do_row;
      emit    = 1'b0;
      do_char = 1'b0;
      do_cell = 1'b0;
      do_row  = 1'b0;
      if (eoi) begin
         // with nothing pending the count and cell flag are already clear
         do_row      = (col_count != 16'd0) || cell_has;
         pred_quoted = 1'b0;
         quote_pend  = 1'b0;
         swallow_lf  = 1'b0;
      end else if (swallow_lf && b == LF_CHAR) begin
         swallow_lf = 1'b0;
      end else begin
         swallow_lf = 1'b0;
         if (quote_pend && b == QUOTE_CHAR) begin
            quote_pend = 1'b0;
            do_char    = 1'b1;
         end else begin
            if (quote_pend) begin
               quote_pend  = 1'b0;
               pred_quoted = 1'b0;
            end
            if (b == QUOTE_CHAR) begin
               if (pred_quoted) quote_pend = 1'b1;
               else pred_quoted = 1'b1;
            end else if (!pred_quoted && b == cfg_delim) begin
               do_cell = 1'b1;
            end else if (!pred_quoted && (b == LF_CHAR || b == CR_CHAR)) begin
               do_row     = 1'b1;
               swallow_lf = (b == CR_CHAR);
            end else begin
               do_char = 1'b1;
            end
         end
      end

      tok.kind        = KIND_CHAR;
      tok.ch          = 8'd0;
      tok.column      = col_count;
      tok.cell_kept   = 1'b0;
      tok.row_columns = 16'd0;
      if (do_char && column_kept(col_count)) begin
         emit     = 1'b1;
         tok.ch   = b;
         cell_has = 1'b1;
      end
      if (do_cell) begin
         emit      = column_kept(col_count);
         tok.kind  = KIND_CELL_END;
         cell_has  = 1'b0;
         col_count = (col_count == COUNT_MAX) ? COUNT_MAX : col_count + 16'd1;
      end
      if (do_row) begin
         emit            = 1'b1;
         tok.kind        = KIND_ROW_END;
         tok.cell_kept   = column_kept(col_count);
         tok.row_columns = (col_count == COUNT_MAX) ? COUNT_MAX : col_count + 16'd1;
         col_count       = 16'd0;
         cell_has        = 1'b0;
      end
      return emit;
   endfunction

   task automatic send_word(input logic [7:0] b, input logic eoi);
      token_t tok;
      if (items_sent >= N_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      if (!quiet && $urandom_range(0, 9) == 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(0, 17)) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eoi;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      if (tokenize_byte(b, eoi, tok) && !typed_row)
         expected_tokens.insert(expected_tokens.size(), tok);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [63:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_DELIMITER_CHAR: cfg_delim    = val[7:0];
         CSR_LAST_COLUMN:    cfg_last_col = val[5:0];
         CSR_MASK_ENABLE:    cfg_mask_en  = val[0];
         CSR_COLUMN_MASK:    cfg_col_mask = val;
         default: ;
      endcase
   endtask

   task automatic configure(input logic [7:0] d, input logic [5:0] last, input logic men,
                            input logic [63:0] mask);
      drain();
      write_csr(CSR_DELIMITER_CHAR, {56'd0, d});
      write_csr(CSR_LAST_COLUMN, {58'd0, last});
      write_csr(CSR_MASK_ENABLE, {63'd0, men});
      write_csr(CSR_COLUMN_MASK, mask);
   endtask

   task automatic dir_pred(input logic [7:0] b, input logic eoi);
      dir_row_t r;
      r           = '0;
      r.data      = b;
      r.eoi       = eoi;
      dir_tab.insert(dir_tab.size(), r);
   endtask

   task automatic dir_want(input logic [7:0] b, input logic eoi, input logic has,
                           input kind_type kind, input logic [7:0] ch,
                           input logic [15:0] col, input logic kept,
                           input logic [15:0] cols);
      dir_row_t r;
      r                       = '0;
      r.data                  = b;
      r.eoi                   = eoi;
      r.typed                 = 1'b1;
      r.has_token             = has;
      r.token.kind            = kind;
      r.token.ch              = ch;
      r.token.column          = col;
      r.token.cell_kept       = kept;
      r.token.row_columns     = cols;
      dir_tab.insert(dir_tab.size(), r);
   endtask

   // one CSV row with random content, or a short burst of raw noise
   task automatic send_chunk();
      int         ncols;
      int         clen;
      bit         quoted;
      logic [7:0] ch;
      if ($urandom_range(0, 7) == 0) begin
         repeat ($urandom_range(1, 6))
            send_word(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
      end else begin
         ncols = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 6);
         for (int c = 0; c < ncols; c++) begin
            quoted = ($urandom_range(0, 3) == 0);
            clen   = (ncols > 8) ? $urandom_range(0, 1) : $urandom_range(0, 4);
            if (quoted) send_word(QUOTE_CHAR, 1'b0);
            repeat (clen) begin
               case ($urandom_range(0, 7))
                  0: ch = 8'($urandom_range(0, 255));
                  1: begin
                     if (!quoted) ch = 8'(8'h30 + $urandom_range(0, 9));
                     else begin
                        case ($urandom_range(0, 3))
                           0: ch = CR_CHAR;
                           1: ch = LF_CHAR;
                           2: ch = cfg_delim;
                           default: ch = QUOTE_CHAR;
                        endcase
                     end
                  end
                  default: ch = 8'(8'h61 + $urandom_range(0, 25));
               endcase
               send_word(ch, 1'b0);
               if (quoted && ch == QUOTE_CHAR) send_word(QUOTE_CHAR, 1'b0);
            end
            if (quoted) send_word(QUOTE_CHAR, 1'b0);
            if (c != ncols - 1) send_word(cfg_delim, 1'b0);
         end
         case ($urandom_range(0, 4))
            1: send_word(LF_CHAR, 1'b0);
            2: send_word(CR_CHAR, 1'b0);
            3: send_word(8'($urandom_range(0, 255)), 1'b1);
            default: begin
               send_word(CR_CHAR, 1'b0);
               send_word(LF_CHAR, 1'b0);
            end
         endcase
      end
   endtask

   // receiver pacing: random ready bursts, one long hold-off on request
   initial begin : rsp_pace
      int n;
      forever begin
         if (hold_reqs != hold_done) begin
            rsp_tready <= 1'b0;
            hold_done   = hold_reqs;
            n           = HOLD_CYCLES;
         end else if (quiet || $urandom_range(0, 2) != 0) begin
            rsp_tready <= 1'b1;
            n          = $urandom_range(1, 30);
         end else begin
            rsp_tready <= 1'b0;
            n          = $urandom_range(1, 18);
         end
         repeat (n) @(negedge clock);
      end
   end

   always @(posedge clock) begin : rsp_check
      token_t got;
      token_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind        = kind_type'(rsp_tuser);
         got.ch          = rsp_tdata[7:0];
         got.column      = rsp_tdata[23:8];
         got.cell_kept   = rsp_tdata[24];
         got.row_columns = rsp_tdata[40:25];
         if (expected_tokens.size() == 0) begin
            $error("unexpected word: kind %0d column %0d", got.kind, got.column);
            mismatch_count++;
         end else begin
            want = expected_tokens.pop_front();
            if (got.kind !== want.kind) begin
               $error("kind: expected %0d, actual %0d", want.kind, got.kind);
               mismatch_count++;
            end
            if (got.ch !== want.ch) begin
               $error("char_out: expected %0d, actual %0d", want.ch, got.ch);
               mismatch_count++;
            end
            if (got.column !== want.column) begin
               $error("column: expected %0d, actual %0d", want.column, got.column);
               mismatch_count++;
            end
            if (got.cell_kept !== want.cell_kept) begin
               $error("cell_kept: expected %0d, actual %0d", want.cell_kept, got.cell_kept);
               mismatch_count++;
            end
            if (got.row_columns !== want.row_columns) begin
               $error("row_columns: expected %0d, actual %0d",
                      want.row_columns, got.row_columns);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      logic [7:0]  d;
      logic [5:0]  last;
      logic        men;
      logic [63:0] mask;
      int          phase;
      int          start;

      // defaults: comma delimiter, every column up to 63 kept
      dir_want(8'h61, 1'b0, 1'b1, KIND_CHAR, 8'h61, 16'd0, 1'b0, 16'd0);
      dir_want(8'hFF, 1'b0, 1'b1, KIND_CHAR, 8'hFF, 16'd0, 1'b0, 16'd0);
      dir_want(8'h00, 1'b0, 1'b1, KIND_CHAR, 8'h00, 16'd0, 1'b0, 16'd0);
      dir_want(8'd44, 1'b0, 1'b1, KIND_CELL_END, 8'h00, 16'd0, 1'b0, 16'd0);
      dir_pred(QUOTE_CHAR, 1'b0);
      dir_pred(8'd44, 1'b0);          // delimiter inside quotes is data
      dir_pred(QUOTE_CHAR, 1'b0);
      dir_pred(QUOTE_CHAR, 1'b0);     // doubled quote
      dir_pred(QUOTE_CHAR, 1'b0);
      dir_pred(8'h78, 1'b0);          // closes quoting, byte kept
      dir_pred(8'h62, 1'b0);
      dir_pred(QUOTE_CHAR, 1'b0);     // opens quoting mid-cell
      dir_pred(CR_CHAR, 1'b0);
      dir_pred(QUOTE_CHAR, 1'b0);
      dir_pred(CR_CHAR, 1'b0);        // closes quoting and ends the row
      dir_want(LF_CHAR, 1'b0, 1'b0, KIND_CHAR, 8'h00, 16'd0, 1'b0, 16'd0);
      dir_want(LF_CHAR, 1'b0, 1'b1, KIND_ROW_END, 8'h00, 16'd0, 1'b1, 16'd1);
      dir_want(8'hFF, 1'b1, 1'b0, KIND_CHAR, 8'h00, 16'd0, 1'b0, 16'd0);
      dir_pred(8'h7A, 1'b0);
      dir_pred(8'd44, 1'b0);
      dir_want(8'h00, 1'b1, 1'b1, KIND_ROW_END, 8'h00, 16'd1, 1'b1, 16'd2);
      dir_pred(QUOTE_CHAR, 1'b0);
      dir_want(QUOTE_CHAR, 1'b1, 1'b0, KIND_CHAR, 8'h00, 16'd0, 1'b0, 16'd0);
      dir_want(8'd44, 1'b0, 1'b1, KIND_CELL_END, 8'h00, 16'd0, 1'b0, 16'd0);
      dir_want(8'h00, 1'b1, 1'b1, KIND_ROW_END, 8'h00, 16'd1, 1'b1, 16'd2);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < dir_tab.size(); i++) begin
         typed_row = dir_tab[i].typed;
         send_word(dir_tab[i].data, dir_tab[i].eoi);
         if (dir_tab[i].typed && dir_tab[i].has_token)
            expected_tokens.insert(expected_tokens.size(), dir_tab[i].token);
      end
      typed_row = 1'b0;

      phase = 0;
      while (items_sent < N_ITEMS) begin
         mask = {$urandom, $urandom};
         case (phase)
            0: configure(8'h00, 6'd0, 1'b1, 64'd0);
            1: configure(8'hFF, 6'd63, 1'b1, '1);
            2: configure(QUOTE_CHAR, 6'd5, 1'b0, mask);
            3: configure(CR_CHAR, 6'd63, 1'b1, mask);
            4: begin
               last = 6'($urandom_range(0, 63));
               men  = 1'($urandom_range(0, 1));
               configure(LF_CHAR, last, men, mask);
            end
            5: begin
               configure(8'd44, 6'd63, 1'b0, mask);
               hold_reqs++;   // sender keeps offering until the input stalls
            end
            default: begin
               case ($urandom_range(0, 5))
                  0: d = 8'd44;
                  1: d = 8'h3B;
                  2: d = 8'h09;
                  3: d = 8'h7C;
                  default: d = 8'($urandom_range(0, 255));
               endcase
               last = $urandom_range(0, 1) ? 6'd63 : 6'($urandom_range(0, 12));
               men  = 1'($urandom_range(0, 1));
               case ($urandom_range(0, 3))
                  0: mask = '1;
                  1: mask = 64'd0;
                  2: mask = 64'h5555_5555_5555_5555;
                  default: ;
               endcase
               configure(d, last, men, mask);
            end
         endcase
         start = items_sent;
         while (items_sent - start < PHASE_ITEMS && items_sent < N_ITEMS) send_chunk();
         phase++;
      end

      drain();
      if (mismatch_count == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/core/csvct_pkg.sv
rtl/core/csvct_front.sv
rtl/core/csvct_queue.sv
rtl/core/csvct_back.sv
rtl/core/csv_cell_tokenizer_core.sv
tb/sv/tb.sv
